// ===== rtl/bole_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the bounded ordered list engine.
// No dependencies.
package bole_pkg;

    typedef enum logic [2:0] {
        FN_INS_HEAD = 3'd0,
        FN_INS_TAIL = 3'd1,
        FN_INS_POS  = 3'd2,
        FN_DEL_HEAD = 3'd3,
        FN_DEL_TAIL = 3'd4,
        FN_DEL_VAL  = 3'd5,
        FN_CLEAR    = 3'd6,
        FN_DUMP     = 3'd7
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ALLOC = 5'b00010,
        S_TRAV  = 5'b00100,
        S_LINK  = 5'b01000,
        S_FREE  = 5'b10000
    } state_t;

endpackage

// ===== rtl/bounded_ordered_list_engine_core.sv =====
`timescale 1ns / 1ps
// Bounded ordered list engine: linked list over a slot pool in two memories.
// Depends on bole_pkg.
//
// One command is taken when start is high and busy is low. Clear, and any
// command that fails at once (insert into a full list, delete or dump of an
// empty list), leaves busy low and answers in the cycle after acceptance.
// Other commands walk the list one node per clock, limited by the next-slot
// memory read that feeds the next read address, and answer in the first cycle
// that busy is low again. An insert at the head passes only the alloc state;
// an insert at list index k > 0 (append: k = length) allocates, walks to
// node k - 1 and links. A delete at the head answers from the walk state;
// a delete at index k > 0, or by value past the head, walks, then frees.
// A dump walks the whole list and gives one element per cycle.
// Every result shows on the result ports for one cycle with done high and
// cannot be stalled; last marks the final result of a command.
module bounded_ordered_list_engine_core
    import bole_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         func,
    input  logic signed [31:0] value,
    input  logic [7:0]         position,
    output logic               done,
    output logic [1:0]         status,
    output logic signed [31:0] element,
    output logic               last
);

    localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int K_W    = (CNT_W > 8) ? CNT_W : 8;

    state_t                  state_reg, state_next;
    func_t                   op_reg, op_next;
    logic [VALUE_BITS-1:0]   vstore_reg, vstore_next;
    logic [CNT_W-1:0]        tgt_reg, tgt_next;
    logic                    hins_reg, hins_next;
    logic [CNT_W-1:0]        len_reg, len_next;
    logic [CNT_W-1:0]        fill_reg, fill_next;
    logic [SLOT_W-1:0]       head_reg, head_next;
    logic [SLOT_W-1:0]       free_head_reg, free_head_next;
    logic [SLOT_W-1:0]       ptr_reg, ptr_next;
    logic [SLOT_W-1:0]       prev_reg, prev_next;
    logic [SLOT_W-1:0]       slot_reg, slot_next;
    logic [SLOT_W-1:0]       idx_reg, idx_next;
    logic                    done_reg, done_next;
    status_t                 status_reg, status_next;
    logic [31:0]             element_reg, element_next;
    logic                    last_reg, last_next;

    logic [VALUE_BITS-1:0]   elem_mem [CAPACITY];
    logic [SLOT_W-1:0]       link_mem [CAPACITY];
    logic [VALUE_BITS-1:0]   elem_rdata;
    logic [SLOT_W-1:0]       link_rdata;
    logic [SLOT_W-1:0]       rd_addr;
    logic                    elem_we;
    logic [SLOT_W-1:0]       elem_waddr;
    logic                    link_we;
    logic [SLOT_W-1:0]       link_waddr;
    logic [SLOT_W-1:0]       link_wdata;

    logic [VALUE_BITS-1:0]   value_ext;
    logic [31:0]             elem_out;
    func_t                   func_in;
    logic                    is_ins;
    logic [K_W-1:0]          pos_m1;
    logic [K_W-1:0]          len_k;
    logic [CNT_W-1:0]        ins_k;
    logic [CNT_W-1:0]        len_m1;
    logic                    last_node;
    logic                    hit;
    logic [SLOT_W-1:0]       alloc_slot;

    generate
        if (VALUE_BITS > 32) begin : g_vin_wide
            assign value_ext = {{(VALUE_BITS - 32){value[31]}}, value};
            assign elem_out  = elem_rdata[31:0];
        end else if (VALUE_BITS == 32) begin : g_vin_eq
            assign value_ext = value;
            assign elem_out  = elem_rdata;
        end else begin : g_vin_narrow
            assign value_ext = value[VALUE_BITS-1:0];
            assign elem_out  = {{(32 - VALUE_BITS){elem_rdata[VALUE_BITS-1]}}, elem_rdata};
        end
    endgenerate

    assign func_in = func_t'(func);
    assign is_ins  = (func_in == FN_INS_HEAD) || (func_in == FN_INS_TAIL)
                  || (func_in == FN_INS_POS);
    assign pos_m1  = (position <= 8'd1) ? K_W'(0) : K_W'(position - 8'd1);
    assign len_k   = K_W'(len_reg);
    assign len_m1  = len_reg - CNT_W'(1);

    always_comb
    begin
        case (func_in)
            FN_INS_HEAD: ins_k = '0;
            FN_INS_TAIL: ins_k = len_reg;
            default:     ins_k = (pos_m1 > len_k) ? len_reg : CNT_W'(pos_m1);
        endcase
    end

    assign last_node  = (CNT_W'(idx_reg) == len_m1);
    assign alloc_slot = (fill_reg != len_reg) ? free_head_reg : fill_reg[SLOT_W-1:0];

    always_comb
    begin
        case (op_reg)
            FN_DEL_VAL: hit = (elem_rdata == vstore_reg);
            FN_DUMP:    hit = 1'b0;
            default:    hit = (CNT_W'(idx_reg) == tgt_reg);
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        vstore_next    = vstore_reg;
        tgt_next       = tgt_reg;
        hins_next      = hins_reg;
        len_next       = len_reg;
        fill_next      = fill_reg;
        head_next      = head_reg;
        free_head_next = free_head_reg;
        ptr_next       = ptr_reg;
        prev_next      = prev_reg;
        slot_next      = slot_reg;
        idx_next       = idx_reg;
        done_next      = 1'b0;
        status_next    = STAT_OK;
        element_next   = '0;
        last_next      = 1'b1;
        rd_addr        = head_reg;
        elem_we        = 1'b0;
        elem_waddr     = alloc_slot;
        link_we        = 1'b0;
        link_waddr     = slot_reg;
        link_wdata     = head_reg;

        case (state_reg)
            S_IDLE:
            begin
                rd_addr = is_ins ? free_head_reg : head_reg;
                if (start)
                begin
                    op_next     = func_in;
                    vstore_next = value_ext;
                    ptr_next    = head_reg;
                    idx_next    = '0;
                    case (func_in)
                        FN_INS_HEAD, FN_INS_TAIL, FN_INS_POS:
                        begin
                            hins_next = (ins_k == '0);
                            tgt_next  = ins_k - CNT_W'(1);
                            if (len_reg == CNT_W'(CAPACITY))
                            begin
                                done_next   = 1'b1;
                                status_next = STAT_FULL;
                            end else begin
                                state_next = S_ALLOC;
                            end
                        end
                        FN_CLEAR:
                        begin
                            len_next  = '0;
                            fill_next = '0;
                            head_next = '0;
                            done_next = 1'b1;
                        end
                        default:
                        begin
                            tgt_next = (func_in == FN_DEL_TAIL) ? len_m1 : '0;
                            if (len_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = STAT_EMPTY;
                            end else begin
                                state_next = S_TRAV;
                            end
                        end
                    endcase
                end
            end
            S_ALLOC:
            begin
                slot_next  = alloc_slot;
                elem_we    = 1'b1;
                elem_waddr = alloc_slot;
                if (fill_reg != len_reg)
                    free_head_next = link_rdata;
                else
                    fill_next = fill_reg + CNT_W'(1);
                if (hins_reg)
                begin
                    link_we    = 1'b1;
                    link_waddr = alloc_slot;
                    link_wdata = head_reg;
                    head_next  = alloc_slot;
                    len_next   = len_reg + CNT_W'(1);
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    state_next = S_TRAV;
                end
            end
            S_TRAV:
            begin
                rd_addr = link_rdata;
                if (op_reg == FN_DUMP)
                begin
                    done_next    = 1'b1;
                    element_next = elem_out;
                    last_next    = last_node;
                    if (last_node)
                        state_next = S_IDLE;
                end
                if (hit && (op_reg == FN_INS_HEAD || op_reg == FN_INS_TAIL
                            || op_reg == FN_INS_POS))
                begin
                    link_we    = 1'b1;
                    link_waddr = slot_reg;
                    link_wdata = link_rdata;
                    prev_next  = ptr_reg;
                    state_next = S_LINK;
                end else if (hit) begin
                    if (idx_reg == '0)
                    begin
                        head_next      = link_rdata;
                        link_we        = 1'b1;
                        link_waddr     = ptr_reg;
                        link_wdata     = free_head_reg;
                        free_head_next = ptr_reg;
                        len_next       = len_reg - CNT_W'(1);
                        done_next      = 1'b1;
                        state_next     = S_IDLE;
                    end else begin
                        link_we    = 1'b1;
                        link_waddr = prev_reg;
                        link_wdata = link_rdata;
                        slot_next  = ptr_reg;
                        state_next = S_FREE;
                    end
                end else if (op_reg == FN_DEL_VAL && last_node) begin
                    done_next   = 1'b1;
                    status_next = STAT_NOT_FOUND;
                    state_next  = S_IDLE;
                end else begin
                    ptr_next  = link_rdata;
                    prev_next = ptr_reg;
                    idx_next  = idx_reg + SLOT_W'(1);
                end
            end
            S_LINK:
            begin
                link_we    = 1'b1;
                link_waddr = prev_reg;
                link_wdata = slot_reg;
                len_next   = len_reg + CNT_W'(1);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_FREE:
            begin
                link_we        = 1'b1;
                link_waddr     = slot_reg;
                link_wdata     = free_head_reg;
                free_head_next = slot_reg;
                len_next       = len_reg - CNT_W'(1);
                done_next      = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (elem_we)
            elem_mem[elem_waddr] <= vstore_reg;
        if (link_we)
            link_mem[link_waddr] <= link_wdata;
        elem_rdata <= elem_mem[rd_addr];
        link_rdata <= link_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            fill_reg      <= '0;
            head_reg      <= '0;
            free_head_reg <= '0;
            done_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            fill_reg      <= fill_next;
            head_reg      <= head_next;
            free_head_reg <= free_head_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        vstore_reg  <= vstore_next;
        tgt_reg     <= tgt_next;
        hins_reg    <= hins_next;
        ptr_reg     <= ptr_next;
        prev_reg    <= prev_next;
        slot_reg    <= slot_next;
        idx_reg     <= idx_next;
        status_reg  <= status_next;
        element_reg <= element_next;
        last_reg    <= last_next;
    end

    assign busy    = (state_reg != S_IDLE);
    assign done    = done_reg;
    assign status  = status_reg;
    assign element = element_reg;
    assign last    = last_reg;

endmodule

// ===== rtl/bole_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for bounded_ordered_list_engine_core, bound into that module.
// Depends on bole_pkg.
module bole_checker
    import bole_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic [2:0]         func,
    input logic               done,
    input logic [1:0]         status,
    input logic signed [31:0] element,
    input logic               last
);

    // a dump streams elements back to back until its last transfer
    a_dump_stream: assert property (@(posedge clk) disable iff (!rst_n)
        done && !last |=> done)
        else $error("dump stream broken");

    a_dump_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done && !last |-> busy && status == STAT_OK)
        else $error("non-final result outside a dump");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != STAT_OK |-> element == 32'sd0 && last)
        else $error("failure result carries data");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && func == FN_CLEAR |=> done && status == STAT_OK && last && !busy)
        else $error("clear did not complete");

endmodule

bind bounded_ordered_list_engine_core bole_checker u_bole_checker (.*);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for bounded_ordered_list_engine_core: directed and random command streams,
// each result checked against a queue-based list predictor. Depends on bole_pkg.
module testbench;
    import bole_pkg::*;

    localparam int CAPACITY       = 64;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        status_t            status;
        logic signed [31:0] element;
        logic               last;
    } list_result_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         func;
    logic signed [31:0] value;
    logic [7:0]         position;
    logic               done;
    logic [1:0]         status;
    logic signed [31:0] element;
    logic               last;

    logic signed [31:0] list_contents[$];
    list_result_t       pending_results[$];
    int                 error_count = 0;
    int                 idle_pct = 0;
    int                 stall_cycles = 0;

    bounded_ordered_list_engine_core #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (32)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .func     (func),
        .value    (value),
        .position (position),
        .done     (done),
        .status   (status),
        .element  (element),
        .last     (last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic void predict_command(func_t op, logic signed [31:0] v,
                                            logic [7:0] p);
        int           k;
        int           hit;
        list_result_t r;
        r.status  = STAT_OK;
        r.element = '0;
        r.last    = 1'b1;
        hit       = -1;
        case (op)
            FN_INS_HEAD, FN_INS_TAIL, FN_INS_POS:
            begin
                if (list_contents.size() >= CAPACITY)
                    r.status = STAT_FULL;
                else
                begin
                    if (op == FN_INS_HEAD)
                        k = 0;
                    else if (op == FN_INS_TAIL)
                        k = list_contents.size();
                    else
                        k = (p <= 1) ? 0 : int'(p) - 1;
                    if (k >= list_contents.size())
                        list_contents.push_back(v);
                    else
                        list_contents.insert(k, v);
                end
            end
            FN_DEL_HEAD, FN_DEL_TAIL:
            begin
                if (list_contents.size() == 0)
                    r.status = STAT_EMPTY;
                else if (op == FN_DEL_HEAD)
                    void'(list_contents.pop_front());
                else
                    void'(list_contents.pop_back());
            end
            FN_DEL_VAL:
            begin
                foreach (list_contents[i])
                    if (hit < 0 && list_contents[i] == v)
                        hit = i;
                if (list_contents.size() == 0)
                    r.status = STAT_EMPTY;
                else if (hit < 0)
                    r.status = STAT_NOT_FOUND;
                else
                    list_contents.delete(hit);
            end
            FN_CLEAR:
                list_contents.delete();
            default:
            begin
                if (list_contents.size() == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    foreach (list_contents[i])
                    begin
                        r.element = list_contents[i];
                        r.last    = (i == list_contents.size() - 1);
                        pending_results.push_back(r);
                    end
                    return;
                end
            end
        endcase
        pending_results.push_back(r);
    endfunction

    // start stays high between back-to-back transfers
    task automatic send_command(func_t op, logic signed [31:0] v, logic [7:0] p);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        start    <= 1'b1;
        func     <= op;
        value    <= v;
        position <= p;
        do
            @(posedge clk);
        while (busy);
        predict_command(op, v, p);
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    function automatic logic signed [31:0] pick_value();
        if ($urandom_range(1) == 0)
            return $urandom;
        return $signed($urandom_range(8)) - 4;
    endfunction

    task automatic test_empty_list();
        send_command(FN_DUMP, 32'sd0, 8'd0);
        send_command(FN_DEL_HEAD, 32'sd0, 8'd0);
        send_command(FN_DEL_TAIL, 32'sd0, 8'd0);
        send_command(FN_DEL_VAL, 32'sd0, 8'd0);
    endtask

    task automatic test_inserts();
        send_command(FN_INS_HEAD, 32'h7fffffff, 8'd0);
        send_command(FN_INS_TAIL, 32'h80000000, 8'd0);
        send_command(FN_INS_POS, 32'sd10, 8'd0);
        send_command(FN_INS_POS, 32'sd11, 8'd1);
        send_command(FN_INS_POS, 32'sd12, 8'd255);
        send_command(FN_INS_POS, 32'sd13, 8'd3);
        send_command(FN_DUMP, 32'hffffffff, 8'hff);
    endtask

    task automatic test_deletes();
        send_command(FN_DEL_VAL, 32'sd12345, 8'd0);
        send_command(FN_DEL_VAL, 32'h80000000, 8'd0);
        send_command(FN_INS_HEAD, 32'sd5, 8'd0);
        send_command(FN_INS_TAIL, 32'sd5, 8'd0);
        send_command(FN_DEL_VAL, 32'sd5, 8'd0);
        send_command(FN_DUMP, 32'sd0, 8'd0);
        send_command(FN_DEL_HEAD, 32'sd0, 8'd0);
        send_command(FN_DEL_TAIL, 32'sd0, 8'd0);
        send_command(FN_CLEAR, 32'sd0, 8'd0);
        send_command(FN_DUMP, 32'sd0, 8'd0);
        send_command(FN_DEL_HEAD, 32'sd0, 8'd0);
    endtask

    task automatic test_full_list();
        send_command(FN_CLEAR, 32'sd0, 8'd0);
        repeat (CAPACITY)
            send_command(func_t'($urandom_range(2)), pick_value(),
                         8'($urandom_range(70)));
        send_command(FN_INS_HEAD, pick_value(), 8'd0);
        send_command(FN_INS_TAIL, pick_value(), 8'd0);
        send_command(FN_INS_POS, pick_value(), 8'd30);
        send_command(FN_DUMP, 32'sd0, 8'd0);
        send_command(FN_DEL_VAL, list_contents[CAPACITY - 1], 8'd0);
        send_command(FN_INS_POS, 32'sd99, 8'd33);
        send_command(FN_DEL_TAIL, 32'sd0, 8'd0);
        send_command(FN_DUMP, 32'sd0, 8'd0);
    endtask

    task automatic test_random_traffic(int count, int gap_pct);
        int                 n;
        int                 r;
        func_t              op;
        logic signed [31:0] v;
        logic [7:0]         p;
        idle_pct = gap_pct;
        repeat (count)
        begin
            n = list_contents.size();
            r = $urandom_range(99);
            v = pick_value();
            if ($urandom_range(3) == 0)
                p = 8'($urandom_range(255));
            else
                p = 8'($urandom_range(n + 2));
            if (r < 40)
                op = func_t'($urandom_range(2));
            else if (r < 62)
                op = ($urandom_range(1) == 0) ? FN_DEL_HEAD : FN_DEL_TAIL;
            else if (r < 78)
            begin
                op = FN_DEL_VAL;
                if (n > 0 && $urandom_range(9) < 7)
                    v = list_contents[$urandom_range(n - 1)];
            end
            else if (r < 90)
                op = FN_DUMP;
            else if (r < 93)
                op = FN_CLEAR;
            else
                op = func_t'($urandom_range(7));
            send_command(op, v, p);
        end
    endtask

    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result status %0d element %0d last %0b",
                         $time, status, element, last);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                begin
                    $display("%0t: status expected %0d, got %0d",
                             $time, want.status, status);
                    error_count++;
                end
                if (element !== want.element)
                begin
                    $display("%0t: element expected %0d, got %0d",
                             $time, want.element, element);
                    error_count++;
                end
                if (last !== want.last)
                begin
                    $display("%0t: last expected %0b, got %0b",
                             $time, want.last, last);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        while (stall_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        rst_n    <= 1'b0;
        start    <= 1'b0;
        func     <= FN_INS_HEAD;
        value    <= '0;
        position <= '0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 35;
        test_empty_list();
        test_inserts();
        test_deletes();
        wait_for_results();
        test_full_list();
        wait_for_results();
        test_random_traffic(20, 35);
        wait_for_results();
        test_random_traffic(20, 77);
        wait_for_results();
        test_random_traffic(20, 0);

        wait_for_results();
        repeat (CAPACITY + 8)
            @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
